>>> rtl/ring_scatter_upsampler_core_assert.svh
// ----------------------------------------------------------------------------
// ring_scatter_upsampler_core_assert.svh
// assertion macros used by the upsampler datapath
// ----------------------------------------------------------------------------
`ifndef RING_SCATTER_UPSAMPLER_CORE_ASSERT_SVH
`define RING_SCATTER_UPSAMPLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RSU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define RSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/rsu_pkg.sv
// ----------------------------------------------------------------------------
// rsu_pkg
// shared widths, op codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rsu_pkg;

   localparam int RATIO_W  = 4;
   localparam int SAMPLE_W = 16;
   localparam int WIDX_W   = 7;
   localparam int WEIGHT_W = 18;
   localparam int ACC_W    = 32;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic take;
      logic step;
      logic reduce;
      logic emit;
      logic pass;
      logic issue;
      logic clear;
      logic load_weight;
   } dp_cmd_type;

   typedef struct packed {
      logic pass_thru;
      logic reduced;
      logic phase_zero;
      logic scat_last;
      logic clear_last;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/rsu_ctrl.sv
// ----------------------------------------------------------------------------
// rsu_ctrl
// sequencer for ring clearing, tick handling, scatter and weight loads
// ----------------------------------------------------------------------------
module rsu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_op,
   output logic                   req_stall,
   input  rsu_pkg::dp_status_type stat,
   output rsu_pkg::dp_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_REDUCE = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_EMIT   = 8'b0001_0000,
      ST_SCAT   = 8'b0010_0000,
      ST_DRAIN  = 8'b0100_0000,
      ST_PASS   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == rsu_pkg::OP_LOAD) begin
                  cmd.load_weight = 1'b1;
               end else begin
                  cmd.take = 1'b1;
                  if (stat.pass_thru) begin
                     state_in = ST_PASS;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = ST_REDUCE;
                  end
               end
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (stat.reduced) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.phase_zero ? ST_SCAT : ST_IDLE;
            end
         end
         ST_SCAT: begin
            cmd.issue = 1'b1;
            if (stat.scat_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (stat.out_free) begin
               cmd.pass = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> rtl/rsu_datapath.sv
// ----------------------------------------------------------------------------
// rsu_datapath
// accumulator ring, weight table, pointers, scatter pipeline and output word
// ----------------------------------------------------------------------------
`include "ring_scatter_upsampler_core_assert.svh"

module rsu_datapath #(
   parameter int MAX_RATIO      = 8,
   parameter int ZERO_CROSSINGS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rsu_pkg::RATIO_W-1:0]         csr_wr_data,
   input  logic signed [rsu_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [rsu_pkg::WIDX_W-1:0]          req_weight_index,
   input  logic signed [rsu_pkg::WEIGHT_W-1:0] req_weight_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [rsu_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  rsu_pkg::dp_cmd_type                 cmd,
   output rsu_pkg::dp_status_type              stat
);

   localparam int RING_DEPTH   = 2 * MAX_RATIO * ZERO_CROSSINGS;
   localparam int WEIGHT_DEPTH = RING_DEPTH + 1;
   localparam int PW           = $clog2(RING_DEPTH);
   localparam int LW           = $clog2(RING_DEPTH + 1);
   localparam int WAW          = $clog2(WEIGHT_DEPTH);
   localparam int RW           = $clog2(MAX_RATIO + 1);
   localparam int SW           = rsu_pkg::SAMPLE_W;
   localparam int WW           = rsu_pkg::WEIGHT_W;
   localparam int AW           = rsu_pkg::ACC_W;
   localparam int PRW          = SW + WW;

   logic [rsu_pkg::RATIO_W-1:0] ratio_ff;
   logic [RW-1:0]               eff_ratio;
   logic [LW-1:0]               ring_len;

   logic [LW-1:0]               ptr_ff;
   logic [RW-1:0]               phase_ff;
   logic [PW-1:0]               j_ff;
   logic [PW-1:0]               p_ff;
   logic [PW-1:0]               p_next;

   logic signed [SW-1:0]        sample_ff;
   logic signed [AW-1:0]        ring_mem_ff [RING_DEPTH];
   logic signed [WW-1:0]        wt_mem_ff [WEIGHT_DEPTH];

   logic [PW-1:0]               ring_raddr;
   logic                        ring_we;
   logic [PW-1:0]               ring_waddr;
   logic signed [AW-1:0]        ring_wdata;

   logic signed [AW-1:0]        acc_rd_ff;
   logic signed [WW-1:0]        w_rd_ff;
   logic [PW-1:0]               p1_ff;
   logic                        v1_ff;

   logic signed [PRW-1:0]       prod_in;
   logic signed [PRW-1:0]       prod_ff;
   logic signed [AW-1:0]        acc2_ff;
   logic [PW-1:0]               p2_ff;
   logic                        v2_ff;

   logic signed [PRW:0]         prod_rnd;
   logic signed [PRW-16:0]      scaled;
   logic signed [AW:0]          sum_wide;
   logic signed [AW-1:0]        sum_sat;
   logic signed [SW-1:0]        out_sat;

   logic                        out_valid_ff;
   logic signed [SW-1:0]        out_data_ff;
   logic                        out_free;

   // ratio register and derived ring length
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= {{(rsu_pkg::RATIO_W - 1){1'b0}}, 1'b1};
      end else if (csr_wr_en) begin
         ratio_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (ratio_ff == '0) begin
         eff_ratio = RW'(1);
      end else if (32'(ratio_ff) > MAX_RATIO) begin
         eff_ratio = RW'(MAX_RATIO);
      end else begin
         eff_ratio = RW'(32'(ratio_ff));
      end
   end

   assign ring_len = LW'(32'(eff_ratio) * 2 * ZERO_CROSSINGS);

   // ring pointer and phase
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         phase_ff <= '0;
      end else if (cmd.step) begin
         ptr_ff   <= ptr_ff + LW'(1);
         phase_ff <= phase_ff + RW'(1);
      end else if (cmd.reduce) begin
         if (ptr_ff >= ring_len) begin
            ptr_ff <= ptr_ff - ring_len;
         end
         if (phase_ff >= eff_ratio) begin
            phase_ff <= phase_ff - eff_ratio;
         end
      end
   end

   // scatter and clear counters
   assign p_next = ((LW'(p_ff) + LW'(1)) == ring_len) ? '0 : p_ff + PW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
         p_ff <= '0;
      end else if (cmd.clear) begin
         j_ff <= (j_ff == PW'(RING_DEPTH - 1)) ? '0 : j_ff + PW'(1);
      end else if (cmd.emit) begin
         j_ff <= '0;
         p_ff <= ptr_ff[PW-1:0];
      end else if (cmd.issue) begin
         j_ff <= j_ff + PW'(1);
         p_ff <= p_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample_in;
      end
   end

   // weight table
   always_ff @(posedge clock) begin
      if (cmd.load_weight && (32'(req_weight_index) < WEIGHT_DEPTH)) begin
         wt_mem_ff[WAW'(req_weight_index)] <= req_weight_value;
      end
      w_rd_ff <= wt_mem_ff[WAW'(j_ff)];
   end

   // accumulator ring, one write and one read port
   assign ring_raddr = cmd.issue ? p_ff : ptr_ff[PW-1:0];

   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = j_ff;
      ring_wdata = '0;
      if (v2_ff) begin
         ring_we    = 1'b1;
         ring_waddr = p2_ff;
         ring_wdata = sum_sat;
      end else if (cmd.emit) begin
         ring_we    = 1'b1;
         ring_waddr = ptr_ff[PW-1:0];
      end else if (cmd.clear) begin
         ring_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem_ff[ring_waddr] <= ring_wdata;
      end
      acc_rd_ff <= ring_mem_ff[ring_raddr];
   end

   // scatter pipeline: read, multiply, round and accumulate
   assign prod_in = PRW'(sample_ff) * PRW'(w_rd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p_ff;
      prod_ff <= prod_in;
      acc2_ff <= acc_rd_ff;
      p2_ff   <= p1_ff;
   end

   assign prod_rnd = (PRW + 1)'(prod_ff) + (PRW + 1)'(32768);
   assign scaled   = prod_rnd[PRW:16];
   assign sum_wide = (AW + 1)'(acc2_ff) + (AW + 1)'(scaled);

   always_comb begin
      if (sum_wide[AW] != sum_wide[AW-1]) begin
         sum_sat = sum_wide[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
      end else begin
         sum_sat = sum_wide[AW-1:0];
      end
   end

   // output word
   always_comb begin
      if (acc_rd_ff[AW-1:SW-1] == '0 || acc_rd_ff[AW-1:SW-1] == '1) begin
         out_sat = acc_rd_ff[SW-1:0];
      end else if (acc_rd_ff[AW-1]) begin
         out_sat = {1'b1, {(SW - 1){1'b0}}};
      end else begin
         out_sat = {1'b0, {(SW - 1){1'b1}}};
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.pass) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_data_ff <= out_sat;
      end else if (cmd.pass) begin
         out_data_ff <= sample_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_data_ff;

   // status back to the controller
   assign stat.pass_thru  = (eff_ratio == RW'(1));
   assign stat.reduced    = (ptr_ff < ring_len) && (phase_ff < eff_ratio);
   assign stat.phase_zero = (phase_ff == '0);
   assign stat.scat_last  = (LW'(j_ff) == ring_len - LW'(2));
   assign stat.clear_last = (j_ff == PW'(RING_DEPTH - 1));
   assign stat.pipe_busy  = v1_ff || v2_ff;
   assign stat.out_free   = out_free;

   `RSU_ASSERT_IMPLY(a_emit_ptr, clock, reset, cmd.emit, (ptr_ff < ring_len) && out_free, "emit with bad pointer or busy output")
   `RSU_ASSERT_NEXT(a_word_out, clock, reset, cmd.emit || cmd.pass, out_valid_ff, "result word not presented")
   `RSU_ASSERT_IMPLY(a_wr_port, clock, reset, v2_ff, !cmd.emit && !cmd.clear, "ring write port conflict")
   `RSU_ASSERT_IMPLY(a_load_idle, clock, reset, cmd.load_weight, !v1_ff && !v2_ff && !cmd.issue, "weight load during scatter")

endmodule

>>> rtl/ring_scatter_upsampler_core.sv
// ----------------------------------------------------------------------------
// ring_scatter_upsampler_core
// integer-ratio interpolator scattering weighted samples into an accumulator ring
// ----------------------------------------------------------------------------
// A weight load is taken in the idle state. A tick at ratio 0 or 1 passes
// the sample through. Any other tick goes through accept and pointer step,
// range check, ring read and emit. The range check subtracts until the
// pointer and the phase are back in range: once when either one wraps, and
// more often when the ratio was lowered since the last tick.
// On the tick where the phase wraps, the scatter adds ring length minus one
// read-modify-writes through the ring's one read and one write port, then
// drains the pipeline. While the result word is stalled, the emit waits, and
// so does the next accept. After reset the ring is cleared one entry per
// cycle, all 2 * MAX_RATIO * ZERO_CROSSINGS entries, with req_stall high;
// ratio writes are taken meanwhile.
module ring_scatter_upsampler_core #(
   parameter int MAX_RATIO      = 8,
   parameter int ZERO_CROSSINGS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rsu_pkg::RATIO_W-1:0]         csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [rsu_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [rsu_pkg::WIDX_W-1:0]          req_weight_index,
   input  logic signed [rsu_pkg::WEIGHT_W-1:0] req_weight_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rsu_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   rsu_pkg::dp_cmd_type    cmd;
   rsu_pkg::dp_status_type stat;

   rsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsu_datapath #(
      .MAX_RATIO      (MAX_RATIO),
      .ZERO_CROSSINGS (ZERO_CROSSINGS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_sample_in    (req_sample_in),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sample_out   (rsp_sample_out),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

>>> bench/ring_scatter_upsampler_core_test.sv
// ----------------------------------------------------------------------------
// ring_scatter_upsampler_core_test
// Self-checking bench for the ring scatter upsampler. It first loads the whole
// weight table, then walks a short directed list (pass-through, clamped ratios,
// ignored loads, output saturation), then runs random words in phases that
// change the ratio and the idling of both channels. Every tick result is
// compared in order with a typed row value or a local interpolation predictor.
// ----------------------------------------------------------------------------
module ring_scatter_upsampler_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RATIO      = 8;
   localparam int ZERO_CROSSINGS = 4;
   localparam int RING_DEPTH     = 2 * MAX_RATIO * ZERO_CROSSINGS;
   localparam int WEIGHT_DEPTH   = RING_DEPTH + 1;
   localparam int SETTLE_CYCLES  = 2 * RING_DEPTH + 20;
   localparam int PHASE_ITEMS    = 100;
   localparam int PHASE_COUNT    = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int DIR_ROWS       = 25;

   localparam longint ACC_MAX = 64'sh7fffffff;
   localparam longint ACC_MIN = -64'sh80000000;

   localparam int PHASE_RATIO [PHASE_COUNT] = '{2, 8, 3, 15, 5, 1, 4, 0, 7, 6, 8, 2};

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [rsu_pkg::RATIO_W-1:0]  ratio;
      logic                         op;
      logic [rsu_pkg::SAMPLE_W-1:0] sample;
      logic [rsu_pkg::WIDX_W-1:0]   widx;
      logic [rsu_pkg::WEIGHT_W-1:0] wval;
      logic                         typed;
      logic [rsu_pkg::SAMPLE_W-1:0] want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      '{4'd1,  rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b1, 16'h7fff},
      '{4'd1,  rsu_pkg::OP_TICK, 16'h8000, 7'd0,   18'h00000, 1'b1, 16'h8000},
      '{4'd1,  rsu_pkg::OP_TICK, 16'h0000, 7'd0,   18'h00000, 1'b1, 16'h0000},
      '{4'd1,  rsu_pkg::OP_TICK, 16'hffff, 7'd0,   18'h00000, 1'b1, 16'hffff},
      '{4'd1,  rsu_pkg::OP_LOAD, 16'h0000, 7'd127, 18'h1ffff, 1'b0, 16'h0000},
      '{4'd1,  rsu_pkg::OP_LOAD, 16'h0000, 7'd65,  18'h20000, 1'b0, 16'h0000},
      '{4'd0,  rsu_pkg::OP_TICK, 16'h5a5a, 7'd0,   18'h00000, 1'b1, 16'h5a5a},
      '{4'd0,  rsu_pkg::OP_LOAD, 16'h0000, 7'd0,   18'h1ffff, 1'b0, 16'h0000},
      '{4'd0,  rsu_pkg::OP_LOAD, 16'h0000, 7'd1,   18'h1ffff, 1'b0, 16'h0000},
      '{4'd0,  rsu_pkg::OP_LOAD, 16'h0000, 7'd2,   18'h20000, 1'b0, 16'h0000},
      '{4'd0,  rsu_pkg::OP_LOAD, 16'h0000, 7'd64,  18'h20000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h8000, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd15, rsu_pkg::OP_TICK, 16'h8000, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd2,  rsu_pkg::OP_TICK, 16'h1234, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd2,  rsu_pkg::OP_TICK, 16'hedcb, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd2,  rsu_pkg::OP_TICK, 16'h0100, 7'd0,   18'h00000, 1'b0, 16'h0000},
      '{4'd8,  rsu_pkg::OP_TICK, 16'h7fff, 7'd0,   18'h00000, 1'b0, 16'h0000}
   };

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                csr_wr_en        = 1'b0;
   logic [rsu_pkg::RATIO_W-1:0]         csr_wr_data      = '0;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   logic                                req_op           = rsu_pkg::OP_TICK;
   logic signed [rsu_pkg::SAMPLE_W-1:0] req_sample_in    = '0;
   logic [rsu_pkg::WIDX_W-1:0]          req_weight_index = '0;
   logic signed [rsu_pkg::WEIGHT_W-1:0] req_weight_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic signed [rsu_pkg::SAMPLE_W-1:0] rsp_sample_out;

   logic signed [rsu_pkg::ACC_W-1:0]    accum_ring [RING_DEPTH] = '{default: '0};
   logic signed [rsu_pkg::WEIGHT_W-1:0] weight_tab [WEIGHT_DEPTH];
   logic [5:0]                          ring_ptr  = '0;
   logic [2:0]                          phase_cnt = '0;
   logic [rsu_pkg::RATIO_W-1:0]         ratio_reg = 4'd1;

   logic signed [rsu_pkg::SAMPLE_W-1:0] expected_samples [$];
   logic signed [rsu_pkg::SAMPLE_W-1:0] due_sample;
   int                                  mismatches = 0;
   int                                  gap_pct    = 0;
   int                                  stall_pct  = 0;
   int                                  hold_asks  = 0;
   int                                  hold_seen  = 0;
   int                                  hold_left  = 0;

   ring_scatter_upsampler_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_sample_in    (req_sample_in),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what,
                                  input logic signed [rsu_pkg::SAMPLE_W-1:0] got,
                                  input logic signed [rsu_pkg::SAMPLE_W-1:0] want);
      if (mismatches < 100)
         $display("%0t ns %s: got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic interpolate_word(input logic op,
                                   input logic signed [rsu_pkg::SAMPLE_W-1:0] s,
                                   input logic [rsu_pkg::WIDX_W-1:0] idx,
                                   input logic signed [rsu_pkg::WEIGHT_W-1:0] w,
                                   input bit typed,
                                   input logic signed [rsu_pkg::SAMPLE_W-1:0] typed_want);
      int                                  r;
      int                                  len;
      int                                  p;
      longint                              prod;
      longint                              sum;
      logic signed [rsu_pkg::SAMPLE_W-1:0] out_now;
      if (op == rsu_pkg::OP_LOAD) begin
         if (idx < WEIGHT_DEPTH)
            weight_tab[idx] = w;
         return;
      end
      r = (ratio_reg == 0) ? 1 : (ratio_reg > MAX_RATIO) ? MAX_RATIO : int'(ratio_reg);
      if (r == 1) begin
         out_now = s;
      end else begin
         len = r * 2 * ZERO_CROSSINGS;
         phase_cnt = 3'((int'(phase_cnt) + 1) % r);
         ring_ptr = 6'((int'(ring_ptr) + 1) % len);
         sum = longint'(accum_ring[ring_ptr]);
         out_now = (sum > 32767) ? 16'sh7fff : (sum < -32768) ? 16'sh8000 : 16'(sum);
         accum_ring[ring_ptr] = '0;
         if (phase_cnt == 0) begin
            p = int'(ring_ptr);
            for (int j = 0; j < len - 1; j++) begin
               prod = (longint'(s) * longint'(weight_tab[j]) + 32768) >>> 16;
               sum = longint'(accum_ring[p]) + prod;
               if (sum > ACC_MAX)
                  sum = ACC_MAX;
               else if (sum < ACC_MIN)
                  sum = ACC_MIN;
               accum_ring[p] = 32'(sum);
               p = (p + 1) % len;
            end
         end
      end
      expected_samples.push_back(typed ? typed_want : out_now);
   endtask

   task automatic send_word(input logic op, input logic signed [rsu_pkg::SAMPLE_W-1:0] s,
                            input logic [rsu_pkg::WIDX_W-1:0] idx,
                            input logic signed [rsu_pkg::WEIGHT_W-1:0] w,
                            input bit typed,
                            input logic signed [rsu_pkg::SAMPLE_W-1:0] typed_want);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_sample_in    <= s;
      req_weight_index <= idx;
      req_weight_value <= w;
      do @(posedge clock); while (req_stall);
      interpolate_word(op, s, idx, w, typed, typed_want);
   endtask

   task automatic set_ratio(input logic [rsu_pkg::RATIO_W-1:0] v);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ratio_reg = v;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
         IDLE_SEND: begin gap_pct = 48; stall_pct = 0;  end
         IDLE_RECV: begin gap_pct = 0;  stall_pct = 48; end
         default:   begin gap_pct = 19; stall_pct = 19; end
      endcase
   endtask

   // receiver side: random stall, or a long hold when asked
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected word", rsp_sample_out, '0);
         end else begin
            due_sample = expected_samples.pop_front();
            if (rsp_sample_out !== due_sample)
               report_mismatch("sample_out", rsp_sample_out, due_sample);
         end
      end
   end

   initial begin
      logic                                op;
      logic signed [rsu_pkg::SAMPLE_W-1:0] s;
      logic [rsu_pkg::WIDX_W-1:0]          idx;
      logic signed [rsu_pkg::WEIGHT_W-1:0] w;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      set_ratio(4'd1);

      // fill the whole weight table before any scatter can read it
      for (int k = 0; k < WEIGHT_DEPTH; k++) begin
         if (k % 16 == 3)
            w = 18'($urandom);
         else
            w = 18'(int'($urandom_range(0, 65535)) - 32768);
         send_word(rsu_pkg::OP_LOAD, 16'($urandom), 7'(k), w, 1'b0, '0);
      end

      for (int k = 0; k < DIR_ROWS; k++) begin
         if (DIRECTED[k].ratio != ratio_reg)
            set_ratio(DIRECTED[k].ratio);
         send_word(DIRECTED[k].op, DIRECTED[k].sample, DIRECTED[k].widx, DIRECTED[k].wval,
                   DIRECTED[k].typed, DIRECTED[k].want);
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         set_ratio(4'(PHASE_RATIO[ph]));
         set_idling(idle_mode_type'(ph % 4));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 30)
               hold_asks <= hold_asks + 1;
            if (ph == 0 && n == 70) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (expected_samples.size() != 0);
            end
            if ($urandom_range(0, 99) < 15) begin
               op = rsu_pkg::OP_LOAD;
               s  = 16'($urandom);
               if ($urandom_range(0, 4) == 0)
                  idx = 7'($urandom);
               else
                  idx = 7'($urandom_range(0, WEIGHT_DEPTH - 1));
               case ($urandom_range(0, 9)) inside
                  0:       w = 18'sh1ffff;
                  1:       w = 18'sh20000;
                  [2:4]:   w = 18'($urandom);
                  default: w = 18'(int'($urandom_range(0, 32767)) - 16384);
               endcase
            end else begin
               op  = rsu_pkg::OP_TICK;
               idx = 7'($urandom);
               w   = 18'($urandom);
               case ($urandom_range(0, 9))
                  0:       s = 16'sh7fff;
                  1:       s = 16'sh8000;
                  default: s = 16'($urandom);
               endcase
            end
            send_word(op, s, idx, w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ring_scatter_upsampler_core: match");
      else
         $display("ring_scatter_upsampler_core: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("ring_scatter_upsampler_core: mismatch");
      $finish;
   end

endmodule
